// ===== rtl/sha512_pkg.sv =====
// Package with the SHA-512 constants, functions and shared types of the stream hasher.
`default_nettype none
package sha512_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_INIT,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_word;    // store the input word at the fill slot
        logic       load_pad;     // write the pad pattern at pad_slot
        logic [3:0] pad_slot;
        logic [1:0] pad_kind;     // see PAD_* codes
        logic       init_work;    // copy hash state into working variables
        logic       round_en;     // run one round
        logic [6:0] round_idx;
        logic       add_state;    // add working variables into hash state
        logic       reset_state;  // restore initial values and clear counters
        logic       out_load;     // load output register with digest word
        logic [2:0] out_sel;
    } dp_cmd_t;

    localparam logic [1:0] PAD_ZERO   = 2'd0;
    localparam logic [1:0] PAD_MARK   = 2'd1;
    localparam logic [1:0] PAD_LENGTH = 2'd2;

    localparam logic [63:0] INITIAL_H [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [63:0] PAD_MARK_WORD = 64'h8000000000000000;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sha512_ctrl.sv =====
// Controller state machine of the SHA-512 stream hasher.
`default_nettype none
module sha512_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_fire,
    input  wire logic                  in_last,
    input  wire logic [3:0]            in_count,
    input  wire logic [3:0]            fill_idx,
    input  wire logic                  out_busy,
    output logic                       in_ready,
    output sha512_pkg::dp_cmd_t        cmd
);
    import sha512_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [6:0]  round_reg, round_next;
    logic [3:0]  slot_reg, slot_next;
    logic [2:0]  out_reg, out_next;
    logic        final_reg, final_next;   // block being hashed is the length block
    logic        mark_reg, mark_next;     // 0x80 mark still owed
    logic        pad_owed_reg, pad_owed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            slot_reg  <= '0;
            out_reg   <= '0;
            final_reg <= 1'b0;
            mark_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            slot_reg  <= slot_next;
            out_reg   <= out_next;
            final_reg <= final_next;
            mark_reg  <= mark_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        slot_next  = slot_reg;
        out_next   = out_reg;
        final_next = final_reg;
        mark_next  = mark_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.round_idx = round_reg;
        cmd.pad_slot  = slot_reg;
        cmd.out_sel   = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load_word = 1'b1;
                    if (in_last)
                    begin
                        mark_next = (in_count >= 4'd8);
                        slot_next = fill_idx + 4'd1;
                        final_next = 1'b0;
                        if (fill_idx == 4'd15)
                            state_next = ST_INIT;
                        else
                            state_next = ST_PAD;
                    end
                    else if (fill_idx == 4'd15)
                    begin
                        final_next = 1'b0;
                        mark_next  = 1'b0;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_PAD:
            begin
                // One slot per cycle: mark, zeros, and the length in slot 15.
                cmd.load_pad = 1'b1;
                if (mark_reg)
                begin
                    cmd.pad_kind = PAD_MARK;
                    mark_next = 1'b0;
                end
                else if (slot_reg == 4'd15 && final_reg)
                    cmd.pad_kind = PAD_LENGTH;
                else
                    cmd.pad_kind = PAD_ZERO;
                slot_next = slot_reg + 4'd1;
                if (slot_reg == 4'd15)
                    state_next = ST_INIT;
                else if (slot_reg == 4'd14 && !mark_reg)
                    final_next = 1'b1;
                else if (slot_reg == 4'd14 && mark_reg)
                    final_next = 1'b0;
                if (slot_reg == 4'd15 && !final_reg && mark_reg)
                    final_next = 1'b0;
            end
            ST_INIT:
            begin
                cmd.init_work = 1'b1;
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == 7'd79)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                cmd.add_state = 1'b1;
                round_next = '0;
                if (final_reg)
                begin
                    out_next = '0;
                    state_next = ST_EMIT;
                end
                else if (pad_owed_reg)
                begin
                    slot_next = '0;
                    state_next = ST_PAD;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_busy)
                begin
                    cmd.out_load = 1'b1;
                    out_next = out_reg + 3'd1;
                    if (out_reg == 3'd7)
                    begin
                        cmd.reset_state = 1'b1;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // A padding run is owed after a block when the message ended but the
    // length block has not been hashed yet; slot_reg wraps to zero then.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pad_owed_reg <= 1'b0;
        else
            pad_owed_reg <= pad_owed_next;
    end

    always_comb
    begin
        pad_owed_next = pad_owed_reg;
        if (state_reg == ST_IDLE && in_fire)
            pad_owed_next = in_last;
        else if (state_reg == ST_PAD && slot_reg == 4'd15 && !final_reg)
            pad_owed_next = 1'b1;
        else if (state_reg == ST_FINAL && final_reg)
            pad_owed_next = 1'b0;
    end

endmodule
`default_nettype wire

// ===== rtl/sha512_dp.sv =====
// Datapath of the SHA-512 stream hasher: schedule window, rounds, hash state, output register.
`default_nettype none
module sha512_dp
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  sha512_pkg::dp_cmd_t       cmd,
    input  wire logic [63:0]          in_word,
    input  wire logic [3:0]           in_count,
    input  wire logic                 in_last,
    output logic [3:0]                fill_idx,
    output logic                      out_busy,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [63:0]               m_word,
    output logic                      m_last
);
    import sha512_pkg::*;

    logic [63:0] w_reg [16];
    logic [63:0] v_reg [8];
    logic [63:0] h_reg [8];
    logic [63:0] len_reg;
    logic [3:0]  fill_reg;
    logic        ov_reg;
    logic [63:0] od_reg;
    logic        ol_reg;

    logic [3:0]  cnt;
    logic [63:0] word_in, mask, mark;
    logic [63:0] w15, w2, s0, s1, w_new, w_cur, a, e, t1, t2;
    logic [3:0]  slot;
    logic [63:0] pad_val;

    assign fill_idx = fill_reg;
    assign out_busy = ov_reg && !m_ready;
    assign m_valid  = ov_reg;
    assign m_word   = od_reg;
    assign m_last   = ol_reg;

    always_comb
    begin
        cnt = (in_count > 4'd8) ? 4'd8 : in_count;
        if (!in_last)
            cnt = 4'd8;
        mask = ~64'd0 << (7'd64 - {cnt[3:0], 3'b000});
        if (cnt == 4'd0)
            mask = '0;
        mark = (cnt < 4'd8) ? (64'h80 << (6'd56 - {cnt[2:0], 3'b000})) : 64'd0;
        word_in = (in_word & mask) | mark;
    end

    always_comb
    begin
        slot  = cmd.round_idx[3:0];
        w15   = w_reg[slot + 4'd1];
        w2    = w_reg[slot + 4'd14];
        s0    = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
        s1    = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
        w_new = w_reg[slot] + s0 + w_reg[slot + 4'd9] + s1;
        w_cur = (cmd.round_idx >= 7'd16) ? w_new : w_reg[slot];
        a  = v_reg[0];
        e  = v_reg[4];
        t1 = v_reg[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
           + ((e & v_reg[5]) ^ (~e & v_reg[6])) + ROUND_K[cmd.round_idx] + w_cur;
        t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
           + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        case (cmd.pad_kind)
            PAD_MARK:   pad_val = PAD_MARK_WORD;
            PAD_LENGTH: pad_val = len_reg;
            default:    pad_val = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
            w_reg[fill_reg] <= word_in;
        else if (cmd.load_pad)
            w_reg[cmd.pad_slot] <= pad_val;
        else if (cmd.round_en)
            w_reg[slot] <= w_cur;
        if (cmd.init_work)
            v_reg <= h_reg;
        else if (cmd.round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (cmd.out_load)
        begin
            od_reg <= h_reg[cmd.out_sel];
            ol_reg <= (cmd.out_sel == 3'd7);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg    <= INITIAL_H;
            len_reg  <= '0;
            fill_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_word)
            begin
                fill_reg <= fill_reg + 4'd1;
                len_reg  <= len_reg + {57'd0, cnt, 3'b000};
            end
            if (cmd.add_state)
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            if (cmd.reset_state)
            begin
                h_reg    <= INITIAL_H;
                len_reg  <= '0;
                fill_reg <= '0;
            end
            if (cmd.out_load)
                ov_reg <= 1'b1;
            else if (m_ready)
                ov_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sha512_stream_hasher_top.sv =====
// Top level of the SHA-512 stream hasher.
//  channel | dir | tdata                                  | tuser | tlast
//  s_axis  | in  | [63:0] msg_word, [67:64] byte_count     | -     | last_word
//  m_axis  | out | [63:0] digest_word                     | -     | digest_last
// A non-last word is stored in the fill slot; the 16th word of a block also runs it
// (load, 80 rounds at one per round unit pass, state add).
// A last word adds padding at one slot per cycle, one or two blocks, then
// eight digest items. Reset restores the initial hash values at once.
// Input stalls while a block runs; output stalls hold the digest sequence.
`default_nettype none
module sha512_stream_hasher_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // msg_word[63:0], byte_count[67:64], zeros
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // digest_word[63:0]
    output logic             m_axis_tlast
);
    import sha512_pkg::*;

    dp_cmd_t    cmd;
    logic [3:0] fill_idx;
    logic       out_busy;
    logic       in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    sha512_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_last  (s_axis_tlast),
        .in_count (s_axis_tdata[67:64]),
        .fill_idx (fill_idx),
        .out_busy (out_busy),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    sha512_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_word  (s_axis_tdata[63:0]),
        .in_count (s_axis_tdata[67:64]),
        .in_last  (s_axis_tlast),
        .fill_idx (fill_idx),
        .out_busy (out_busy),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_word   (m_axis_tdata),
        .m_last   (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ===== bench/tb_sha512_stream_hasher_top.sv =====
// Self-checking stream testbench for the SHA-512 hasher with a built-in digest predictor.
`timescale 1ns / 100ps
module tb_sha512_stream_hasher_top;
    import sha512_pkg::*;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  count;
        logic        last;
    } msg_item_t;

    typedef struct {
        logic [63:0] word;
        logic        last;
    } digest_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;

    msg_item_t    pending_words[$];
    digest_item_t expected_digests[$];

    // Predictor copy of the hash state and the block being filled.
    logic [63:0] hash_h[8];
    logic [63:0] block_words[16];
    int          fill_slot;
    logic [63:0] msg_bits;

    int sent_count;
    int accept_count;
    int total_items;
    int digest_count;
    int messages_done;
    int mismatch_count;
    bit timed_out;

    sha512_stream_hasher_top u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        ror64 = (x >> n) | (x << (64 - n));
    endfunction

    function automatic void compress_block();
        logic [63:0] w[80];
        logic [63:0] v[8];
        logic [63:0] t1;
        logic [63:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = block_words[i];
        for (int i = 16; i < 80; i++)
            w[i] = w[i-16] + w[i-7]
                + (ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7))
                + (ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6));
        for (int i = 0; i < 8; i++)
            v[i] = hash_h[i];
        for (int i = 0; i < 80; i++)
        begin
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_h[i] = hash_h[i] + v[i];
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++)
            hash_h[i] = INITIAL_H[i];
        fill_slot = 0;
        msg_bits  = '0;
    endfunction

    // Absorbs one accepted item; a last item pads, finishes and queues the digest.
    function automatic void absorb_word(input msg_item_t it);
        int          nbytes;
        logic [63:0] word;
        digest_item_t d;
        if (!it.last)
        begin
            block_words[fill_slot] = it.word;
            msg_bits  = msg_bits + 64;
            fill_slot = fill_slot + 1;
            if (fill_slot == 16)
            begin
                compress_block();
                fill_slot = 0;
            end
            return;
        end
        nbytes = (it.count > 8) ? 8 : int'(it.count);
        if (nbytes == 0)
            word = '0;
        else
            word = it.word & (~64'd0 << (64 - 8 * nbytes));
        if (nbytes < 8)
            word = word | (64'h80 << (56 - 8 * nbytes));
        msg_bits = msg_bits + 64'(8 * nbytes);
        block_words[fill_slot] = word;
        fill_slot = fill_slot + 1;
        if (nbytes == 8)
        begin
            if (fill_slot == 16)
            begin
                compress_block();
                fill_slot = 0;
            end
            block_words[fill_slot] = PAD_MARK_WORD;
            fill_slot = fill_slot + 1;
        end
        if (fill_slot > 14)
        begin
            for (int i = fill_slot; i < 16; i++)
                block_words[i] = '0;
            compress_block();
            fill_slot = 0;
        end
        for (int i = fill_slot; i < 15; i++)
            block_words[i] = '0;
        block_words[15] = msg_bits;
        compress_block();
        for (int i = 0; i < 8; i++)
        begin
            d.word = hash_h[i];
            d.last = (i == 7);
            expected_digests.push_back(d);
        end
        restart_message();
    endfunction

    function automatic logic [63:0] random_word();
        case ($urandom_range(0, 9))
            0: random_word = '0;
            1: random_word = '1;
            default: random_word = {$urandom(), $urandom()};
        endcase
    endfunction

    // Queues a message of full words followed by a closing word.
    function automatic void queue_message(input int full_words, input logic [63:0] tail,
                                          input logic [3:0] tail_count, input bit odd_counts);
        msg_item_t it;
        for (int i = 0; i < full_words; i++)
        begin
            it.word  = random_word();
            it.count = (odd_counts && $urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                                : 4'd8;
            it.last  = 1'b0;
            pending_words.push_back(it);
        end
        it.word  = tail;
        it.count = tail_count;
        it.last  = 1'b1;
        pending_words.push_back(it);
    endfunction

    function automatic bit quiet_stretch();
        quiet_stretch = (accept_count >= 140) && (accept_count < 220);
    endfunction

    // Input driver: holds an offered item until it is taken.
    always @(negedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && accept_count != sent_count))
        begin
        end
        else if (pending_words.size() != 0 && (quiet_stretch() || $urandom_range(0, 99) >= 29))
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {4'd0, pending_words[0].count, pending_words[0].word};
            s_axis_tlast  <= pending_words[0].last;
            pending_words.pop_front();
            sent_count++;
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= quiet_stretch() || ($urandom_range(0, 99) >= 29);
    end

    always @(posedge clk)
    begin
        msg_item_t it;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            it.word  = s_axis_tdata[63:0];
            it.count = s_axis_tdata[67:64];
            it.last  = s_axis_tlast;
            absorb_word(it);
            if (it.last)
                messages_done++;
            accept_count++;
        end
    end

    // Digest monitor and comparison against the oldest prediction.
    always @(posedge clk)
    begin
        digest_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            digest_count++;
            if (expected_digests.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected digest item %h last %b", m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = expected_digests.pop_front();
                if (m_axis_tdata !== want.word || m_axis_tlast !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("digest item %0d: expected %h last %b, got %h last %b",
                                 digest_count, want.word, want.last,
                                 m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        timed_out = 1'b1;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int n;
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        sent_count     = 0;
        accept_count   = 0;
        digest_count   = 0;
        messages_done  = 0;
        mismatch_count = 0;
        timed_out      = 1'b0;
        restart_message();

        // Directed: empty message, all tail counts, both pad overflow cases,
        // short counts on inner words and junk below the valid bytes.
        queue_message(0, '1, 4'd0, 0);
        queue_message(0, 64'h6162630000000000, 4'd3, 0);
        queue_message(0, '1, 4'd8, 0);
        queue_message(0, '1, 4'd15, 0);
        queue_message(1, '1, 4'd9, 1);
        queue_message(2, 64'h0123456789abcdef, 4'd7, 1);
        queue_message(13, '0, 4'd8, 0);
        queue_message(14, '1, 4'd1, 1);
        queue_message(15, '1, 4'd8, 0);
        queue_message(15, 64'hfedcba9876543210, 4'd6, 1);
        for (int c = 0; c < 16; c++)
            queue_message(0, {$urandom(), $urandom()}, 4'(c), 0);

        // Random messages, mostly short, a few spanning several blocks.
        while (pending_words.size() < 310)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 17);
            queue_message(n, random_word(), 4'($urandom_range(0, 15)), 1);
        end
        total_items = pending_words.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (accept_count == total_items);
        wait (expected_digests.size() == 0);
        repeat (300) @(posedge clk);

        $display("Hashed %0d messages from %0d input items, %0d digest items checked.",
                 messages_done, accept_count, digest_count);
        if (mismatch_count == 0 && expected_digests.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
